/* hdl/ppt_pkg.sv */
// shared types and constants for the proximity penalty table
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = 112;

  localparam logic       OP_STORE = 1'b0;
  localparam logic       OP_QUERY = 1'b1;

  localparam logic [1:0] ST_NEW    = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_QUERY  = 2'd3;

  typedef struct packed {
    logic [15:0] weight;
    logic [31:0] east;
    logic [31:0] north;
    logic [31:0] key;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SQX,
    S_SQY,
    S_ADD,
    S_SQRT,
    S_SCALE,
    S_MULW,
    S_DIV,
    S_ACC,
    S_STORE,
    S_DONE
  } state_t;

endpackage

/* hdl/ppt_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/proximity_penalty_table.sv */
// Proximity penalty table: a table of 64 weighted hazard points in one
// single-port ram. A store word walks the slots (read, then check) until it
// finds its key or passes the last slot, noting the lowest free slot, then
// writes unless the key is new and the table is full. A query word walks
// every slot; a valid entry within reach on both axes goes on through two
// 31x31 squares, a 32-step square root and a 55-step restoring divide.
// One word is in work at a time; the result register lets the next word
// enter while a result waits. The table is empty after reset.
`timescale 1ns / 1ps
module proximity_penalty_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // hazard_key[31:0], north_pos[63:32], east_pos[95:64], weight[111:96],
  // reach[142:112], zero pad
  input  logic [143:0] s_tdata,
  // op
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // penalty[31:0]
  output logic [31:0]  m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser
);

  import ppt_pkg::*;

  state_t state, state_next;

  logic              op;
  logic [31:0]       key;
  logic signed [31:0] north;
  logic signed [31:0] east;
  logic [15:0]       weight;
  logic [30:0]       reach;

  logic [MAX_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  slot;
  logic              found;
  logic              have_free;
  logic [1:0]        status;

  logic [30:0]       dx, dy;
  logic [15:0]       ent_weight;
  logic [61:0]       sqx, sqy;
  logic [63:0]       rad;
  logic [33:0]       rem;
  logic [31:0]       root;
  logic [4:0]        scnt;
  logic [30:0]       diff;
  logic [54:0]       num;
  logic [30:0]       drem;
  logic [23:0]       quo;
  logic [5:0]        dcnt;
  logic [31:0]       sum;

  entry_t            rd_entry, wr_entry;
  logic              we;
  logic [IDX_W-1:0]  ram_addr;

  logic signed [32:0] dn, de;
  logic [31:0]       adn, ade;
  logic              near, key_hit, last, can_add;
  logic [35:0]       rem_s, trial;
  logic [31:0]       div_s;
  logic [32:0]       acc_s;

  ppt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  assign dn      = {north[31], north} - {rd_entry.north[31], rd_entry.north};
  assign de      = {east[31], east} - {rd_entry.east[31], rd_entry.east};
  assign adn     = dn[32] ? 32'(-dn) : dn[31:0];
  assign ade     = de[32] ? 32'(-de) : de[31:0];
  assign near    = (adn < {1'b0, reach}) && (ade < {1'b0, reach});
  assign key_hit = rd_entry.key == key;
  assign last    = idx == IDX_W'(MAX_ENTRIES - 1);
  assign can_add = have_free && (count < CNT_W'(MAX_ENTRIES));

  assign rem_s   = {rem, rad[63:62]};
  assign trial   = {2'b00, root, 2'b01};
  assign div_s   = {drem, num[54]};
  assign acc_s   = {1'b0, sum} + {9'd0, quo};

  assign wr_entry.key    = key;
  assign wr_entry.north  = north;
  assign wr_entry.east   = east;
  assign wr_entry.weight = weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    we         = 1'b0;
    ram_addr   = idx;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (op == OP_STORE) begin
          if (valid[idx] && key_hit) begin
            state_next = S_STORE;
          end else if (last) begin
            state_next = S_STORE;
          end else begin
            state_next = S_READ;
          end
        end else if (valid[idx] && near) begin
          state_next = S_SQX;
        end else if (last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_SQX: state_next = S_SQY;
      S_SQY: state_next = S_ADD;
      S_ADD: state_next = S_SQRT;
      S_SQRT: begin
        if (scnt == 5'd31) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (root < {1'b0, reach}) begin
          state_next = S_MULW;
        end else if (last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_MULW: state_next = S_DIV;
      S_DIV: begin
        if (dcnt == 6'd54) begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = last ? S_DONE : S_READ;
      S_STORE: begin
        ram_addr = slot;
        we       = found || can_add;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_STORE && !found && can_add) begin
        valid[slot] <= 1'b1;
        count       <= count + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op        <= s_tuser;
        key       <= s_tdata[31:0];
        north     <= s_tdata[63:32];
        east      <= s_tdata[95:64];
        weight    <= s_tdata[111:96];
        reach     <= s_tdata[142:112];
        idx       <= '0;
        sum       <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
      end
      S_CHECK: begin
        dx         <= adn[30:0];
        dy         <= ade[30:0];
        ent_weight <= rd_entry.weight;
        if (op == OP_STORE) begin
          if (valid[idx] && key_hit) begin
            slot  <= idx;
            found <= 1'b1;
          end else begin
            if (!valid[idx] && !have_free) begin
              slot      <= idx;
              have_free <= 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end else if (!(valid[idx] && near)) begin
          idx <= idx + 1'b1;
        end
      end
      S_SQX: sqx <= dx * dx;
      S_SQY: sqy <= dy * dy;
      S_ADD: begin
        rad  <= {1'b0, 63'(sqx) + 63'(sqy)};
        rem  <= '0;
        root <= '0;
        scnt <= '0;
      end
      S_SQRT: begin
        // one result bit per cycle, two radicand bits consumed
        if (rem_s >= trial) begin
          rem  <= 34'(rem_s - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_s[33:0];
          root <= {root[30:0], 1'b0};
        end
        rad  <= {rad[61:0], 2'b00};
        scnt <= scnt + 1'b1;
      end
      S_SCALE: begin
        diff <= reach - root[30:0];
        if (!(root < {1'b0, reach})) begin
          idx <= idx + 1'b1;
        end
      end
      S_MULW: begin
        num  <= {47'(ent_weight) * 47'(diff), 8'd0};
        drem <= '0;
        quo  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        // quotient never exceeds 24 bits since diff <= reach
        if (div_s >= {1'b0, reach}) begin
          drem <= 31'(div_s - {1'b0, reach});
          quo  <= {quo[22:0], 1'b1};
        end else begin
          drem <= div_s[30:0];
          quo  <= {quo[22:0], 1'b0};
        end
        num  <= {num[53:0], 1'b0};
        dcnt <= dcnt + 1'b1;
      end
      S_ACC: begin
        sum <= acc_s[32] ? '1 : acc_s[31:0];
        idx <= idx + 1'b1;
      end
      S_STORE: begin
        if (found) begin
          status <= ST_UPDATE;
        end else if (can_add) begin
          status <= ST_NEW;
        end else begin
          status <= ST_FULL;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= (op == OP_QUERY) ? sum : 32'd0;
          m_tuser <= (op == OP_QUERY) ? ST_QUERY : status;
        end
      end
      default: ;
    endcase
  end

endmodule
